FILE: sv/str_pkg.sv
// Shared types, constants and arithmetic helpers for the spherical tilt rotation core
package str_pkg;

   localparam int FRAC_BITS = 16;
   localparam int STEPS = 30;
   localparam int ANG_W = 34;
   localparam int VEC_W = 36;
   localparam int TRIG_W = 32;
   localparam int LON_W = 25;
   localparam int LAT_W = 24;
   localparam int TILT_W = 19;
   localparam int LONIN_W = 20;
   localparam int LATIN_W = 18;
   localparam logic signed [TRIG_W-1:0] INV_GAIN = 32'sd652032874;
   localparam logic [31:0] RAD_TO_TURN = 32'd683565276;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;
   localparam logic [0:0] CSR_TILT = 1'b0;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [ANG_W-1:0] ang_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      ang_type z;
      logic    flip;
   } rot_type;

   function automatic logic signed [ANG_W-1:0] turn_step(input logic [4:0] i);
      logic signed [ANG_W-1:0] t;
      begin
         case (i)
            5'd0: t = 34'sd536870912;
            5'd1: t = 34'sd316933406;
            5'd2: t = 34'sd167458907;
            5'd3: t = 34'sd85004756;
            5'd4: t = 34'sd42667331;
            5'd5: t = 34'sd21354465;
            5'd6: t = 34'sd10679838;
            5'd7: t = 34'sd5340245;
            5'd8: t = 34'sd2670163;
            5'd9: t = 34'sd1335087;
            5'd10: t = 34'sd667544;
            5'd11: t = 34'sd333772;
            5'd12: t = 34'sd166886;
            5'd13: t = 34'sd83443;
            5'd14: t = 34'sd41722;
            5'd15: t = 34'sd20861;
            5'd16: t = 34'sd10430;
            5'd17: t = 34'sd5215;
            5'd18: t = 34'sd2608;
            5'd19: t = 34'sd1304;
            5'd20: t = 34'sd652;
            5'd21: t = 34'sd326;
            5'd22: t = 34'sd163;
            5'd23: t = 34'sd81;
            5'd24: t = 34'sd41;
            5'd25: t = 34'sd20;
            5'd26: t = 34'sd10;
            5'd27: t = 34'sd5;
            5'd28: t = 34'sd3;
            5'd29: t = 34'sd1;
            default: t = 34'sd1;
         endcase
         return t;
      end
   endfunction

endpackage

FILE: sv/spherical_tilt_rotation_core.sv
// Spherical rotation about the x axis: top level pipeline and CSR port
// The core accepts one position per cycle while req_stall is low and returns one result per position, in
// order. Each word passes through 96 register stages (1 + 30 + 2 + 30 + 1 + 30 + 2):
// an input register, three parallel 30-cell sine/cosine rows, two product stages,
// a 30-cell longitude arctangent row, a radius scaling stage, a 30-cell latitude
// arctangent row and two output stages. The whole pipeline advances whenever the
// output word is taken or the output register is empty, and an output stall holds
// every stage. tilt_angle (signed Q3.16 radians) lies at CSR byte
// address 0; write it only while idle.
module spherical_tilt_rotation_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [19:0]         req_lon_in,
   input  logic signed [17:0]         req_lat_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [24:0]                rsp_out_lon,
   output logic signed [23:0]         rsp_out_lat,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [1:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import str_pkg::*;

   localparam logic [31:0] FULL_DEG = 32'(360) << FRAC_BITS;
   localparam int DSH = 32 - FRAC_BITS;
   localparam logic signed [ANG_W-1:0] LA_MAX = ANG_W'(QUARTER_TURN);

   logic signed [TILT_W-1:0] tilt_ff;
   logic adv;

   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(signed'(tilt_ff));
   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1] == CSR_TILT) begin
         tilt_ff <= csr_pwdata[TILT_W-1:0];
      end
   end

   logic out_v_ff;
   assign adv = !out_v_ff || !rsp_stall;
   assign req_stall = !adv;

   // stage A: radians to binary angle
   logic        a_v_ff;
   logic [31:0] a_lon_ff, a_lat_ff, a_tlt_ff;
   function automatic logic [31:0] r2t(input logic signed [23:0] r);
      logic [63:0] p;
      begin
         p = 64'(signed'(r)) * 64'(RAD_TO_TURN) + (64'd1 << (FRAC_BITS - 1));
         return p[FRAC_BITS +: 32];
      end
   endfunction
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (adv) a_v_ff <= req_valid;
      if (adv) begin
         a_lon_ff <= r2t(24'(req_lon_in));
         a_lat_ff <= r2t(24'(req_lat_in));
         a_tlt_ff <= r2t(24'(tilt_ff));
      end
   end

   function automatic rot_type fold(input logic [31:0] b);
      rot_type r;
      logic [31:0] bb;
      begin
         r.flip = (b[31:30] == 2'd1) || (b[31:30] == 2'd2);
         bb = r.flip ? b + HALF_TURN : b;
         r.x = VEC_W'(INV_GAIN);
         r.y = '0;
         r.z = ANG_W'(signed'(bb));
         return r;
      end
   endfunction

   rot_type s_lon, s_lat, s_tlt, e_lon, e_lat, e_tlt;
   logic    e_v;
   assign s_lon = fold(a_lon_ff);
   assign s_lat = fold(a_lat_ff);
   assign s_tlt = fold(a_tlt_ff);

   str_chain #(.VECTOR(1'b0), .SIDE_W(1)) u_sc_lon (
      .clock(clock), .reset(reset), .adv(adv), .vld_in(a_v_ff), .d_in(s_lon),
      .side_in(1'b0), .vld_out(e_v), .d_out(e_lon), .side_out()
   );
   str_chain #(.VECTOR(1'b0), .SIDE_W(1)) u_sc_lat (
      .clock(clock), .reset(reset), .adv(adv), .vld_in(a_v_ff), .d_in(s_lat),
      .side_in(1'b0), .vld_out(), .d_out(e_lat), .side_out()
   );
   str_chain #(.VECTOR(1'b0), .SIDE_W(1)) u_sc_tlt (
      .clock(clock), .reset(reset), .adv(adv), .vld_in(a_v_ff), .d_in(s_tlt),
      .side_in(1'b0), .vld_out(), .d_out(e_tlt), .side_out()
   );

   // stage B: signed trig values and products
   logic signed [TRIG_W-1:0] clo, slo, cla, sla, ct, st;
   assign clo = TRIG_W'(e_lon.flip ? -e_lon.x : e_lon.x);
   assign slo = TRIG_W'(e_lon.flip ? -e_lon.y : e_lon.y);
   assign cla = TRIG_W'(e_lat.flip ? -e_lat.x : e_lat.x);
   assign sla = TRIG_W'(e_lat.flip ? -e_lat.y : e_lat.y);
   assign ct  = TRIG_W'(e_tlt.flip ? -e_tlt.x : e_tlt.x);
   assign st  = TRIG_W'(e_tlt.flip ? -e_tlt.y : e_tlt.y);

   function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
      logic signed [63:0] q;
      begin
         q = p + 64'sd536870912;
         return q >>> 30;
      end
   endfunction

   logic b_v_ff;
   logic signed [TRIG_W-1:0] b_x_ff, b_y_ff, b_z_ff, b_ct_ff, b_st_ff;
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (adv) b_v_ff <= e_v;
      if (adv) begin
         b_x_ff  <= TRIG_W'(rnd30(64'(clo) * 64'(cla)));
         b_y_ff  <= TRIG_W'(rnd30(64'(slo) * 64'(cla)));
         b_z_ff  <= sla;
         b_ct_ff <= ct;
         b_st_ff <= st;
      end
   end

   // stage C: tilt products
   logic c_v_ff;
   logic signed [TRIG_W-1:0] c_x_ff, c_yp_ff, c_zp_ff;
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (adv) c_v_ff <= b_v_ff;
      if (adv) begin
         c_x_ff  <= b_x_ff;
         c_yp_ff <= TRIG_W'(rnd30(64'(b_ct_ff) * 64'(b_y_ff) + 64'(b_st_ff) * 64'(b_z_ff)));
         c_zp_ff <= TRIG_W'(rnd30(64'(b_ct_ff) * 64'(b_z_ff) - 64'(b_st_ff) * 64'(b_y_ff)));
      end
   end

   // first vectoring row: longitude and horizontal radius
   rot_type v1_in, v1_out;
   logic    v1_v;
   logic [2*TRIG_W+1:0] v1_side_in, v1_side;
   assign v1_in.flip = c_x_ff < 0;
   assign v1_in.x = c_x_ff < 0 ? -VEC_W'(c_x_ff) : VEC_W'(c_x_ff);
   assign v1_in.y = c_x_ff < 0 ? -VEC_W'(c_yp_ff) : VEC_W'(c_yp_ff);
   assign v1_in.z = c_x_ff < 0 ? ANG_W'(HALF_TURN) : '0;
   assign v1_side_in = {c_x_ff == 0, c_x_ff < 0, c_yp_ff, c_zp_ff};

   str_chain #(.VECTOR(1'b1), .SIDE_W(2*TRIG_W+2)) u_vec_lon (
      .clock(clock), .reset(reset), .adv(adv), .vld_in(c_v_ff), .d_in(v1_in),
      .side_in(v1_side_in), .vld_out(v1_v), .d_out(v1_out), .side_out(v1_side)
   );

   logic signed [TRIG_W-1:0] v1_yp, v1_zp;
   logic v1_xz, v1_xn;
   logic [31:0] lon_b;
   assign {v1_xz, v1_xn, v1_yp, v1_zp} = v1_side;
   always_comb begin
      if (v1_xz) lon_b = v1_yp > 0 ? QUARTER_TURN : (v1_yp < 0 ? THREE_QUARTER : '0);
      else if (v1_yp == 0) lon_b = v1_xn ? HALF_TURN : '0;
      else lon_b = v1_out.z[31:0];
   end

   // stage D: radius scaling and longitude to degrees
   logic d_v_ff;
   logic signed [VEC_W-1:0] d_r_ff;
   logic signed [TRIG_W-1:0] d_zp_ff;
   logic [31:0] d_lon_ff;
   logic [63:0] lon_p;
   always_comb begin
      lon_p = (64'(lon_b) * 64'd360 + (64'd1 << (31 - FRAC_BITS))) >> DSH;
      if (lon_p[31:0] >= FULL_DEG) lon_p = lon_p - 64'(FULL_DEG);
   end
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else if (adv) d_v_ff <= v1_v;
      if (adv) begin
         d_r_ff   <= VEC_W'(rnd30(64'(v1_out.x) * 64'(INV_GAIN)));
         d_zp_ff  <= v1_zp;
         d_lon_ff <= lon_p[31:0];
      end
   end

   // second vectoring row: latitude
   rot_type v2_in, v2_out;
   logic v2_v;
   logic [34:0] v2_side;
   logic rpos;
   assign rpos = d_r_ff > 0;
   assign v2_in.flip = 1'b0;
   assign v2_in.x = d_r_ff;
   assign v2_in.y = VEC_W'(d_zp_ff);
   assign v2_in.z = '0;

   str_chain #(.VECTOR(1'b1), .SIDE_W(35)) u_vec_lat (
      .clock(clock), .reset(reset), .adv(adv), .vld_in(d_v_ff), .d_in(v2_in),
      .side_in({rpos, d_zp_ff > 0, d_zp_ff < 0, d_lon_ff}), .vld_out(v2_v),
      .d_out(v2_out), .side_out(v2_side)
   );

   logic signed [ANG_W-1:0] la;
   logic [ANG_W-1:0] lam;
   logic [63:0] lat_p;
   always_comb begin
      if (!v2_side[34]) begin
         la = v2_side[33] ? LA_MAX : (v2_side[32] ? -LA_MAX : '0);
      end else begin
         la = v2_out.z;
         if (la > LA_MAX) la = LA_MAX;
         if (la < -LA_MAX) la = -LA_MAX;
      end
      lam = la < 0 ? ANG_W'(-la) : ANG_W'(la);
      lat_p = (64'(lam) * 64'd360 + (64'd1 << (31 - FRAC_BITS))) >> DSH;
   end

   logic v2_neg;
   assign v2_neg = la < 0;

   logic [24:0] out_lon_ff;
   logic signed [23:0] out_lat_ff;
   logic e2_v_ff;
   logic e2_neg_ff;
   logic [31:0] e2_lat_ff, e2_lon_ff;
   always_ff @(posedge clock) begin
      if (reset) e2_v_ff <= 1'b0;
      else if (adv) e2_v_ff <= v2_v;
      if (adv) begin
         e2_neg_ff <= v2_neg;
         e2_lat_ff <= lat_p[31:0];
         e2_lon_ff <= v2_side[31:0];
      end
   end

   logic signed [31:0] lat_d;
   assign lat_d = e2_neg_ff ? -signed'(e2_lat_ff) : signed'(e2_lat_ff);

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= e2_v_ff;
      if (adv) begin
         out_lon_ff <= e2_lon_ff[24:0];
         out_lat_ff <= lat_d[23:0];
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_out_lon = out_lon_ff;
   assign rsp_out_lat = out_lat_ff;
endmodule

FILE: sv/str_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode, with a register stage
module str_cell #(
   parameter int IDX = 0,
   parameter bit VECTOR = 1'b0,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    vld_in,
   input  str_pkg::rot_type        d_in,
   input  logic [SIDE_W-1:0]       side_in,
   output logic                    vld_out,
   output str_pkg::rot_type        d_out,
   output logic [SIDE_W-1:0]       side_out
);
   import str_pkg::*;

   rot_type           d_ff, d_nx;
   logic [SIDE_W-1:0] side_ff;
   logic              vld_ff;
   logic              dir;
   vec_type           dx, dy;

   always_comb begin
      dx = d_in.y >>> IDX;
      dy = d_in.x >>> IDX;
      dir = VECTOR ? (d_in.y > 0) : (d_in.z >= 0);
      d_nx = d_in;
      if (dir != VECTOR) begin
         d_nx.x = d_in.x - dx;
         d_nx.y = d_in.y + dy;
      end else begin
         d_nx.x = d_in.x + dx;
         d_nx.y = d_in.y - dy;
      end
      if (dir) d_nx.z = VECTOR ? d_in.z + turn_step(5'(IDX)) : d_in.z - turn_step(5'(IDX));
      else     d_nx.z = VECTOR ? d_in.z - turn_step(5'(IDX)) : d_in.z + turn_step(5'(IDX));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         d_ff    <= d_nx;
         side_ff <= side_in;
      end
   end

   assign vld_out  = vld_ff;
   assign d_out    = d_ff;
   assign side_out = side_ff;
endmodule

FILE: sv/str_chain.sv
// A row of CORDIC cells forming one fully unrolled CORDIC
module str_chain #(
   parameter bit VECTOR = 1'b0,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    vld_in,
   input  str_pkg::rot_type        d_in,
   input  logic [SIDE_W-1:0]       side_in,
   output logic                    vld_out,
   output str_pkg::rot_type        d_out,
   output logic [SIDE_W-1:0]       side_out
);
   import str_pkg::*;

   logic              v [0:STEPS];
   rot_type           d [0:STEPS];
   logic [SIDE_W-1:0] s [0:STEPS];

   assign v[0] = vld_in;
   assign d[0] = d_in;
   assign s[0] = side_in;

   for (genvar g = 0; g < STEPS; g++) begin : g_cell
      str_cell #(.IDX(g), .VECTOR(VECTOR), .SIDE_W(SIDE_W)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .vld_in(v[g]), .d_in(d[g]), .side_in(s[g]),
         .vld_out(v[g+1]), .d_out(d[g+1]), .side_out(s[g+1])
      );
   end

   assign vld_out  = v[STEPS];
   assign d_out    = d[STEPS];
   assign side_out = s[STEPS];
endmodule

FILE: sv/str_check.sv
// Port-level checker for the spherical tilt rotation core, with its bind
module str_check (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [24:0]       rsp_out_lon,
   input logic signed [23:0] rsp_out_lat
);
   a_lon_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_lon < 25'd23592960) else $error("longitude out of range");
   a_lat_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_lat <= 24'sd5898240 && rsp_out_lat >= -24'sd5898240))
      else $error("latitude out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_lon))
      else $error("stalled word changed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("stall without back-pressure");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("word after reset");
endmodule

bind spherical_tilt_rotation_core str_check u_str_check (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_lon(rsp_out_lon),
   .rsp_out_lat(rsp_out_lat)
);
